@@ sv/slm_pkg.sv @@
// Shared request codes, sequencer states and data width for the list merge unit.
`default_nettype none

package slm_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REQ_APPEND_A = 2'd0,
        REQ_APPEND_B = 2'd1,
        REQ_MERGE    = 2'd2,
        REQ_CLEAR    = 2'd3
    } req_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } seq_state_t;

endpackage

`default_nettype wire

@@ sv/slm_list_store.sv @@
// One list store: single write port and one registered read port.
`default_nettype none

module slm_list_store #(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [AW-1:0]                    wr_addr,
    input  wire logic signed [slm_pkg::DATA_W-1:0] wr_data,
    input  wire logic [AW-1:0]                    rd_addr,
    output logic signed [slm_pkg::DATA_W-1:0]     rd_data
);
    import slm_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ sv/slm_merge_seq.sv @@
// Merge sequencer: list counts, walk indices, shared compare and result register.
`default_nettype none

module slm_merge_seq #(
    parameter int LIST_DEPTH = 16,
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire slm_pkg::req_t                     req_type,
    output logic                                   wr_a,
    output logic                                   wr_b,
    output logic [AW-1:0]                          wr_addr_a,
    output logic [AW-1:0]                          wr_addr_b,
    output logic [AW-1:0]                          rd_addr_a,
    output logic [AW-1:0]                          rd_addr_b,
    input  wire logic signed [slm_pkg::DATA_W-1:0] rd_a,
    input  wire logic signed [slm_pkg::DATA_W-1:0] rd_b,
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output logic signed [slm_pkg::DATA_W-1:0]      merged_value,
    output logic                                   source_list,
    output logic                                   is_last,
    output logic                                   is_empty,
    output logic                                   append_dropped
);
    import slm_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

    seq_state_t state_reg, state_next;
    logic [CW-1:0] count_a_reg, count_a_next;
    logic [CW-1:0] count_b_reg, count_b_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic          overflow_reg, overflow_next;
    logic          res_valid_reg, res_valid_next;

    logic          accept;
    logic          start;
    logic          can_emit;
    logic          emit;
    logic          has_a;
    logic          has_b;
    logic          both_empty;
    logic          take_a;
    logic          last_step;
    logic [CW-1:0] i_step;
    logic [CW-1:0] j_step;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (emit && last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state decoded controls
    always_comb
    begin
        req_stall = 1'b1;
        emit      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            ST_RUN:
            begin
                emit = can_emit;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign accept   = req_valid && !req_stall;
    assign start    = accept && (req_type == REQ_MERGE);
    assign can_emit = !res_valid_reg || !res_stall;

    // shared compare; a tie goes to list B
    assign has_a      = i_reg < count_a_reg;
    assign has_b      = j_reg < count_b_reg;
    assign both_empty = (count_a_reg == '0) && (count_b_reg == '0);
    assign take_a     = (has_a && has_b) ? (rd_a < rd_b) : has_a;
    assign i_step     = i_reg + CW'(take_a);
    assign j_step     = j_reg + CW'(!take_a);
    assign last_step  = both_empty || ((i_step == count_a_reg) && (j_step == count_b_reg));

    always_comb
    begin
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        overflow_next = overflow_reg;
        wr_a = 1'b0;
        wr_b = 1'b0;
        i_next = i_reg;
        j_next = j_reg;
        if (accept)
        begin
            case (req_type)
                REQ_APPEND_A:
                begin
                    if (count_a_reg == FULL)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        wr_a = 1'b1;
                        count_a_next = count_a_reg + CW'(1);
                    end
                end
                REQ_APPEND_B:
                begin
                    if (count_b_reg == FULL)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        wr_b = 1'b1;
                        count_b_next = count_b_reg + CW'(1);
                    end
                end
                REQ_MERGE:
                begin
                    i_next = '0;
                    j_next = '0;
                end
                REQ_CLEAR:
                begin
                    count_a_next = '0;
                    count_b_next = '0;
                    overflow_next = 1'b0;
                end
                default:
                begin
                    overflow_next = overflow_reg;
                end
            endcase
        end
        else if (emit && !both_empty)
        begin
            i_next = i_step;
            j_next = j_step;
        end
    end

    // read the head that the next step compares; hold it while stalled
    assign wr_addr_a = count_a_reg[AW-1:0];
    assign wr_addr_b = count_b_reg[AW-1:0];
    assign rd_addr_a = i_next[AW-1:0];
    assign rd_addr_b = j_next[AW-1:0];

    assign res_valid_next = emit ? 1'b1 : (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            overflow_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            overflow_reg  <= overflow_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            merged_value   <= both_empty ? '0 : (take_a ? rd_a : rd_b);
            source_list    <= !both_empty && !take_a;
            is_last        <= last_step;
            is_empty       <= both_empty;
            append_dropped <= overflow_reg;
        end
    end

    assign res_valid = res_valid_reg;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (i_reg <= count_a_reg) && (j_reg <= count_b_reg))
        else $error("merge index beyond list count");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last_step) |=> (state_reg == ST_IDLE))
        else $error("run continued after last result");

    a_counts_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) ##1 (state_reg == ST_RUN)
        |-> $stable(count_a_reg) && $stable(count_b_reg))
        else $error("list count changed during merge");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!res_valid_reg || !res_stall))
        else $error("result register overwritten while stalled");

    a_run_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && !both_empty) |-> (has_a || has_b))
        else $error("merge step with both lists used up");

endmodule

`default_nettype wire

@@ sv/sorted_list_merge_unit.sv @@
// Top level of the two-list merge unit: two list stores and the merge sequencer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  req     | in        | req_valid/req_stall  | req_type, value
//  res     | out       | res_valid/res_stall  | merged_value, source_list, is_last,
//          |           |                      | is_empty, append_dropped
//
// Append and clear requests are accepted back to back.
// A merge of n stored elements gives n results, one per cycle while res_stall is low,
// set by the single compare and the one read port of each list store; an empty merge
// gives one. req_stall is high from the cycle after a merge is accepted until its last
// result is loaded; res_stall freezes the walk with the result held in place.
// Reset clears state, counts, indices and flags only; the stores need no clearing pass.
`default_nettype none

module sorted_list_merge_unit #(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire slm_pkg::req_t                     req_type,
    input  wire logic signed [slm_pkg::DATA_W-1:0] value,
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output logic signed [slm_pkg::DATA_W-1:0]      merged_value,
    output logic                                   source_list,
    output logic                                   is_last,
    output logic                                   is_empty,
    output logic                                   append_dropped
);
    import slm_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic                     wr_a;
    logic                     wr_b;
    logic [AW-1:0]            wr_addr_a;
    logic [AW-1:0]            wr_addr_b;
    logic [AW-1:0]            rd_addr_a;
    logic [AW-1:0]            rd_addr_b;
    logic signed [DATA_W-1:0] rd_a;
    logic signed [DATA_W-1:0] rd_b;

    slm_list_store #(.DEPTH(LIST_DEPTH)) u_store_a (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (wr_addr_a),
        .wr_data (value),
        .rd_addr (rd_addr_a),
        .rd_data (rd_a)
    );

    slm_list_store #(.DEPTH(LIST_DEPTH)) u_store_b (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (wr_addr_b),
        .wr_data (value),
        .rd_addr (rd_addr_b),
        .rd_data (rd_b)
    );

    slm_merge_seq #(.LIST_DEPTH(LIST_DEPTH)) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_type       (req_type),
        .wr_a           (wr_a),
        .wr_b           (wr_b),
        .wr_addr_a      (wr_addr_a),
        .wr_addr_b      (wr_addr_b),
        .rd_addr_a      (rd_addr_a),
        .rd_addr_b      (rd_addr_b),
        .rd_a           (rd_a),
        .rd_b           (rd_b),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .merged_value   (merged_value),
        .source_list    (source_list),
        .is_last        (is_last),
        .is_empty       (is_empty),
        .append_dropped (append_dropped)
    );

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the sorted list merge unit: random and directed requests.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import slm_pkg::*;

    localparam int LIST_DEPTH     = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 16;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 40;

    typedef struct packed {
        req_t                     kind;
        logic signed [DATA_W-1:0] data;
        logic                     hold;
    } list_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] merged_value;
        logic                     source_list;
        logic                     is_last;
        logic                     is_empty;
        logic                     append_dropped;
    } merge_out_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     req_valid = 1'b0;
    logic                     req_stall;
    req_t                     req_type = REQ_APPEND_A;
    logic signed [DATA_W-1:0] value = '0;
    logic                     res_valid;
    logic                     res_stall = 1'b0;
    logic signed [DATA_W-1:0] merged_value;
    logic                     source_list;
    logic                     is_last;
    logic                     is_empty;
    logic                     append_dropped;

    // predicted contents of the two list stores
    logic signed [DATA_W-1:0] list_a [LIST_DEPTH];
    logic signed [DATA_W-1:0] list_b [LIST_DEPTH];
    int                       len_a = 0;
    int                       len_b = 0;
    logic                     overflow_seen = 1'b0;

    list_req_t  pending_q [$];
    merge_out_t merge_results_q [$];
    int         queued_cnt = 0;
    int         mismatch_cnt = 0;
    int         idle_cycles = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;

    sorted_list_merge_unit #(
        .LIST_DEPTH(LIST_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .value         (value),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .merged_value  (merged_value),
        .source_list   (source_list),
        .is_last       (is_last),
        .is_empty      (is_empty),
        .append_dropped(append_dropped)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Update the list model with one accepted request; queue the merge output it causes.
    task automatic apply_request(input req_t kind, input logic signed [DATA_W-1:0] data);
        merge_out_t res;
        int         ia;
        int         ib;
        int         total;
        ia    = 0;
        ib    = 0;
        total = len_a + len_b;
        case (kind)
            REQ_APPEND_A:
            begin
                if (len_a < LIST_DEPTH)
                begin
                    list_a[len_a] = data;
                    len_a++;
                end
                else
                    overflow_seen = 1'b1;
            end
            REQ_APPEND_B:
            begin
                if (len_b < LIST_DEPTH)
                begin
                    list_b[len_b] = data;
                    len_b++;
                end
                else
                    overflow_seen = 1'b1;
            end
            REQ_CLEAR:
            begin
                len_a         = 0;
                len_b         = 0;
                overflow_seen = 1'b0;
            end
            default:
            begin
                res.append_dropped = overflow_seen;
                if (total == 0)
                begin
                    res.merged_value = '0;
                    res.source_list  = 1'b0;
                    res.is_last      = 1'b1;
                    res.is_empty     = 1'b1;
                    merge_results_q.push_back(res);
                end
                while (ia < len_a || ib < len_b)
                begin
                    // on a tie take the head of list B
                    if (ia < len_a && (ib >= len_b || list_a[ia] < list_b[ib]))
                    begin
                        res.merged_value = list_a[ia];
                        res.source_list  = 1'b0;
                        ia++;
                    end
                    else
                    begin
                        res.merged_value = list_b[ib];
                        res.source_list  = 1'b1;
                        ib++;
                    end
                    res.is_last  = (ia + ib == total);
                    res.is_empty = 1'b0;
                    merge_results_q.push_back(res);
                end
            end
        endcase
    endtask

    task automatic push_req(input req_t kind, input logic signed [DATA_W-1:0] data,
                            input logic hold = 1'b0);
        list_req_t item;
        item.kind = kind;
        item.data = data;
        item.hold = hold;
        pending_q.push_back(item);
        queued_cnt++;
    endtask

    // One round: noise, or optional clear, two interleaved ascending runs, then merge(s).
    task automatic queue_round();
        logic signed [DATA_W-1:0] pool [2*LIST_DEPTH+8];
        logic signed [DATA_W-1:0] tmp;
        logic signed [DATA_W-1:0] base;
        int                       na;
        int                       nb;
        int                       ra;
        int                       rb;
        int                       n;
        int                       mode;
        // noise: random requests of any kind, lists left unsorted
        if ($urandom_range(5) == 0)
        begin
            repeat ($urandom_range(6, 1))
                push_req(req_t'($urandom_range(3)), $urandom());
            return;
        end
        na   = ($urandom_range(7) == 0) ? $urandom_range(LIST_DEPTH + 3, 10) : $urandom_range(6);
        nb   = ($urandom_range(7) == 0) ? $urandom_range(LIST_DEPTH + 3, 10) : $urandom_range(6);
        n    = na + nb;
        mode = $urandom_range(2);
        for (int k = 0; k < n; k++)
        begin
            case (mode)
                0: pool[k] = $urandom_range(6) - 3;
                1:
                begin
                    case ($urandom_range(3))
                        0:       base = 32'sh8000_0000;
                        1:       base = 32'sh7fff_ffff;
                        2:       base = -1;
                        default: base = 0;
                    endcase
                    pool[k] = base ^ $urandom_range(1);
                end
                default: pool[k] = $urandom();
            endcase
        end
        for (int x = 0; x < n; x++)
            for (int y = 0; y + 1 < n - x; y++)
                if (pool[y] > pool[y+1])
                begin
                    tmp       = pool[y];
                    pool[y]   = pool[y+1];
                    pool[y+1] = tmp;
                end
        if ($urandom_range(9) < 7)
            push_req(REQ_CLEAR, $urandom(), $urandom_range(15) == 0);
        ra = na;
        rb = nb;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(ra + rb - 1) < ra)
            begin
                push_req(REQ_APPEND_A, pool[k]);
                ra--;
            end
            else
            begin
                push_req(REQ_APPEND_B, pool[k]);
                rb--;
            end
        end
        push_req(REQ_MERGE, $urandom());
        if ($urandom_range(3) == 0)
            push_req(REQ_MERGE, $urandom());
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || req_valid || merge_results_q.size() != 0)
            @(negedge clk);
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                apply_request(req_type, value);
            if (!req_valid || !req_stall)
            begin
                // a held request waits until every merge result has come out
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                    !(pending_q[0].hold && merge_results_q.size() != 0))
                begin
                    req_valid <= 1'b1;
                    req_type  <= pending_q[0].kind;
                    value     <= pending_q[0].data;
                    void'(pending_q.pop_front());
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        merge_out_t got;
        merge_out_t exp;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                got = {merged_value, source_list, is_last, is_empty, append_dropped};
                if (merge_results_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("unexpected merge result: value=%0d src=%0b last=%0b",
                                 got.merged_value, got.source_list, got.is_last);
                end
                else
                begin
                    exp = merge_results_q.pop_front();
                    if (got !== exp)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display({"merge result mismatch: exp value=%0d src=%0b last=%0b ",
                                      "empty=%0b dropped=%0b, got value=%0d src=%0b last=%0b ",
                                      "empty=%0b dropped=%0b"},
                                     exp.merged_value, exp.source_list, exp.is_last,
                                     exp.is_empty, exp.append_dropped,
                                     got.merged_value, got.source_list, got.is_last,
                                     got.is_empty, got.append_dropped);
                    end
                end
            end
            res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // end the run when nothing has moved on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int send_pcts  [4];
        int stall_pcts [4];
        int mark;
        send_pcts  = '{0, 81, 0, 31};
        stall_pcts = '{0, 0, 81, 31};
        repeat (10) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // empty merge straight after reset
        push_req(REQ_MERGE, $urandom());
        // extremes with ties at the minimum and at zero
        push_req(REQ_APPEND_A, 32'sh8000_0000);
        push_req(REQ_APPEND_A, 0);
        push_req(REQ_APPEND_A, 32'sh7fff_ffff);
        push_req(REQ_APPEND_B, 32'sh8000_0000);
        push_req(REQ_APPEND_B, 0);
        push_req(REQ_MERGE, $urandom());
        push_req(REQ_CLEAR, $urandom(), 1'b1);
        // fill list A past capacity, leave B empty
        for (int i = 0; i < LIST_DEPTH; i++)
            push_req(REQ_APPEND_A, {i[3:0], 28'h0} ^ 32'h8000_0000);
        push_req(REQ_APPEND_A, $urandom());
        push_req(REQ_MERGE, $urandom());
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = send_pcts[ph];
            stall_pct     = stall_pcts[ph];
            mark          = queued_cnt;
            while (queued_cnt - mark < PHASE_ITEMS)
                queue_round();
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
sv/slm_pkg.sv
sv/slm_list_store.sv
sv/slm_merge_seq.sv
sv/sorted_list_merge_unit.sv
verif/tb_top.sv
